/* sv/block_power_squelch_top_defines.svh */
// Assertion macros for the block power squelch design.
// Included by the top level; no other dependencies.
`ifndef BLOCK_POWER_SQUELCH_TOP_DEFINES_SVH
`define BLOCK_POWER_SQUELCH_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define BPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define BPS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define BPS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BPS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* sv/bps_pkg.sv */
// Shared constants, types and helper functions of the block power squelch.
// Used by the controller, the datapath, the divider and the top level.
`default_nettype none

package bps_pkg;

	// Sizes of the sample store and the arithmetic.
	localparam int MAX_BLOCK     = 1024;
	localparam int ADDR_BITS     = $clog2(MAX_BLOCK);
	localparam int LEN_BITS      = ADDR_BITS + 1;
	localparam int SAMPLE_BITS   = 16;
	localparam int STORE_BITS    = 2 * SAMPLE_BITS;
	localparam int SQ_BITS       = 2 * SAMPLE_BITS - 1;
	localparam int CNT_BITS      = LEN_BITS;
	localparam int SUM_BITS      = SQ_BITS + 1 + LEN_BITS;
	localparam int POWER_BITS    = 32;
	localparam int DIV_STEP_BITS = $clog2(SUM_BITS + 1);
	localparam int FLUSH_BLOCKS  = 5;
	localparam int FLUSH_BITS    = 3;

	// Configuration port.
	localparam int CFG_ADDR_BITS = 2;
	localparam int CFG_DATA_BITS = POWER_BITS;
	localparam logic [CFG_ADDR_BITS-1:0] REG_BLOCK_LENGTH  = 2'd0;
	localparam logic [CFG_ADDR_BITS-1:0] REG_DECIMATION    = 2'd1;
	localparam logic [CFG_ADDR_BITS-1:0] REG_SQUELCH_LEVEL = 2'd2;
	localparam logic [CFG_ADDR_BITS-1:0] REG_COMPLEX_MODE  = 2'd3;

	// Result kinds carried on tuser.
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	// How the previous block leaves the store.
	typedef enum logic [1:0] {
		MODE_NONE,
		MODE_PASS,
		MODE_FLUSH,
		MODE_DROP
	} mode_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FWD,
		ST_START,
		ST_DIV,
		ST_RPT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic commit;
		logic div_start;
		logic report;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last;
		logic out_free;
		logic div_done;
	} sts_t;

	// A length or stride of zero acts as one; larger than the store saturates.
	function automatic logic [LEN_BITS-1:0] clamp_cfg(input logic [LEN_BITS-1:0] v);
		logic [LEN_BITS-1:0] r;
		priority if (v == '0) begin
			r = LEN_BITS'(1);
		end else if (v > LEN_BITS'(MAX_BLOCK)) begin
			r = LEN_BITS'(MAX_BLOCK);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* sv/bps_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// Stand-alone; no package dependencies.
`default_nettype none

module bps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* sv/bps_div.sv */
// Restoring divider that produces one quotient bit per cycle.
// Depends on bps_pkg for the operand widths.
`default_nettype none

module bps_div
	import bps_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [SUM_BITS-1:0] dividend,
	input  wire logic [CNT_BITS-1:0] divisor,
	output logic                     done,
	output logic      [SUM_BITS-1:0] quotient
);

	logic [DIV_STEP_BITS-1:0] step_q;
	logic [CNT_BITS-1:0]      rem_q;
	logic [SUM_BITS-1:0]      quo_q;
	logic [CNT_BITS-1:0]      dsr_q;
	logic [CNT_BITS:0]        trial;
	logic                     fits;

	// One trial subtraction of the shifted remainder.
	assign trial = {rem_q, quo_q[SUM_BITS-1]};
	assign fits  = (trial >= {1'b0, dsr_q});

	// Step counter; the unit is idle when it reaches zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (start) begin
			step_q <= DIV_STEP_BITS'(SUM_BITS);
		end else if (step_q != '0) begin
			step_q <= step_q - 1'b1;
		end
	end

	// Remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (step_q != '0) begin
			rem_q <= fits ? CNT_BITS'(trial - {1'b0, dsr_q}) : trial[CNT_BITS-1:0];
			quo_q <= {quo_q[SUM_BITS-2:0], fits};
		end
	end

	assign done     = (step_q == '0);
	assign quotient = quo_q;

endmodule

`default_nettype wire

/* sv/bps_ctrl.sv */
// Controller state machine of the block power squelch.
// Depends on bps_pkg for the state, command and status types.
`default_nettype none

module bps_ctrl
	import bps_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_FWD;
				end
			end
			ST_FWD: begin
				if (sts.out_free) begin
					state_d = sts.last ? ST_START : ST_IDLE;
				end
			end
			ST_START: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_done) begin
					state_d = ST_RPT;
				end
			end
			ST_RPT: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Command outputs.
	always_comb begin
		s_tready      = 1'b0;
		cmd           = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
			end
			ST_FWD: begin
				cmd.commit = sts.out_free;
			end
			ST_START: begin
				cmd.div_start = 1'b1;
			end
			ST_DIV: begin
			end
			ST_RPT: begin
				cmd.report = sts.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

/* sv/bps_dp.sv */
// Datapath: configuration, sample store, power sum, squelch gate, output beat.
// Depends on bps_pkg, bps_ram and bps_div.
`default_nettype none

module bps_dp
	import bps_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [CFG_ADDR_BITS-1:0] cfg_addr,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
	input  wire logic [STORE_BITS-1:0]    s_tdata,
	input  wire logic                     m_tready,
	output logic                          m_tvalid,
	output logic [STORE_BITS+POWER_BITS-1:0] m_tdata,
	output logic                          m_tuser,
	output logic                          m_tlast,
	input  wire cmd_t                     cmd,
	output sts_t                          sts
);

	// Configuration registers.
	logic [LEN_BITS-1:0]   len_cfg_q;
	logic [LEN_BITS-1:0]   dec_cfg_q;
	logic [POWER_BITS-1:0] squelch_q;
	logic                  cmode_q;

	// Block state.
	logic [ADDR_BITS-1:0]  wpos_q;
	logic [ADDR_BITS-1:0]  phase_q;
	logic [SUM_BITS-1:0]   sum_q;
	logic [CNT_BITS-1:0]   taken_q;
	mode_t                 mode_q;
	logic [FLUSH_BITS-1:0] flush_q;

	// Accepted sample and its squares.
	logic [STORE_BITS-1:0] samp_s1;
	logic [SQ_BITS-1:0]    sqi_s1;
	logic [SQ_BITS-1:0]    sqq_s1;

	// Output beat register.
	logic                   m_valid_q;
	logic                   m_kind_q;
	logic [SAMPLE_BITS-1:0] m_i_q;
	logic [SAMPLE_BITS-1:0] m_q_q;
	logic [POWER_BITS-1:0]  m_pow_q;
	logic                   m_last_q;

	logic [LEN_BITS-1:0]             len_eff;
	logic [LEN_BITS-1:0]             dec_eff;
	logic                            last;
	logic [LEN_BITS-1:0]             phase_inc;
	logic signed [SAMPLE_BITS-1:0]   in_i;
	logic signed [SAMPLE_BITS-1:0]   in_q;
	logic signed [STORE_BITS-1:0]    prod_i;
	logic signed [STORE_BITS-1:0]    prod_q;
	logic [STORE_BITS-1:0]           rd_data;
	logic                            div_done;
	logic [SUM_BITS-1:0]             quotient;
	logic [POWER_BITS-1:0]           avg;
	logic                            emit;
	logic                            pass;
	logic                            out_free;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_cfg_q <= LEN_BITS'(MAX_BLOCK);
			dec_cfg_q <= LEN_BITS'(1);
			squelch_q <= '0;
			cmode_q   <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_BLOCK_LENGTH:  len_cfg_q <= cfg_data[LEN_BITS-1:0];
				REG_DECIMATION:    dec_cfg_q <= cfg_data[LEN_BITS-1:0];
				REG_SQUELCH_LEVEL: squelch_q <= cfg_data[POWER_BITS-1:0];
				REG_COMPLEX_MODE:  cmode_q   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Block position decode.
	assign len_eff   = clamp_cfg(len_cfg_q);
	assign dec_eff   = clamp_cfg(dec_cfg_q);
	assign last      = (({1'b0, wpos_q} + LEN_BITS'(1)) >= len_eff);
	assign phase_inc = {1'b0, phase_q} + LEN_BITS'(1);

	// Squares of the incoming sample; Q reads as zero in real mode.
	assign in_i   = s_tdata[SAMPLE_BITS-1:0];
	assign in_q   = cmode_q ? s_tdata[STORE_BITS-1:SAMPLE_BITS] : '0;
	assign prod_i = in_i * in_i;
	assign prod_q = in_q * in_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			samp_s1 <= {in_q, in_i};
			sqi_s1  <= prod_i[SQ_BITS-1:0];
			sqq_s1  <= prod_q[SQ_BITS-1:0];
		end
	end

	// Sample store: the prior block is read at accept, overwritten at commit.
	bps_ram #(
		.WIDTH(STORE_BITS),
		.DEPTH(MAX_BLOCK)
	) u_store (
		.clk  (clk),
		.we   (cmd.commit),
		.waddr(wpos_q),
		.wdata(samp_s1),
		.re   (cmd.accept),
		.raddr(wpos_q),
		.rdata(rd_data)
	);

	// Average power of the finished block.
	bps_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(sum_q),
		.divisor (taken_q),
		.done    (div_done),
		.quotient(quotient)
	);

	always_comb begin
		priority if (taken_q == '0) begin
			avg = '0;
		end else if (quotient[SUM_BITS-1:POWER_BITS] != '0) begin
			avg = '1;
		end else begin
			avg = quotient[POWER_BITS-1:0];
		end
	end

	// Position, stride and power accumulation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q  <= '0;
			phase_q <= '0;
			sum_q   <= '0;
			taken_q <= '0;
		end else if (cmd.commit) begin
			if (phase_q == '0) begin
				sum_q   <= sum_q + {{(SUM_BITS-SQ_BITS){1'b0}}, sqi_s1}
				                 + {{(SUM_BITS-SQ_BITS){1'b0}}, sqq_s1};
				taken_q <= taken_q + CNT_BITS'(1);
			end
			if (last) begin
				wpos_q  <= '0;
				phase_q <= '0;
			end else begin
				wpos_q  <= wpos_q + ADDR_BITS'(1);
				phase_q <= (phase_inc >= dec_eff) ? '0 : phase_inc[ADDR_BITS-1:0];
			end
		end else if (cmd.report) begin
			sum_q   <= '0;
			taken_q <= '0;
		end
	end

	// Squelch gate decision at the end of each block.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_NONE;
			flush_q <= '0;
		end else if (cmd.report) begin
			priority if (squelch_q == '0 || avg >= squelch_q) begin
				mode_q  <= MODE_PASS;
				flush_q <= '0;
			end else if (flush_q < FLUSH_BITS'(FLUSH_BLOCKS)) begin
				mode_q  <= MODE_FLUSH;
				flush_q <= flush_q + FLUSH_BITS'(1);
			end else begin
				mode_q  <= MODE_DROP;
			end
		end
	end

	assign pass     = (mode_q == MODE_PASS);
	assign emit     = pass || (mode_q == MODE_FLUSH);
	assign out_free = !m_valid_q || m_tready;

	// Output beat valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if ((cmd.commit && emit) || cmd.report) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Output beat payload: forwarded sample or power report.
	always_ff @(posedge clk) begin
		if (cmd.commit && emit) begin
			m_kind_q <= KIND_SAMPLE;
			m_i_q    <= pass ? rd_data[SAMPLE_BITS-1:0] : '0;
			m_q_q    <= pass ? rd_data[STORE_BITS-1:SAMPLE_BITS] : '0;
			m_pow_q  <= '0;
			m_last_q <= last;
		end else if (cmd.report) begin
			m_kind_q <= KIND_REPORT;
			m_i_q    <= '0;
			m_q_q    <= '0;
			m_pow_q  <= avg;
			m_last_q <= 1'b0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {m_pow_q, m_q_q, m_i_q};
	assign m_tuser  = m_kind_q;
	assign m_tlast  = m_last_q;

	assign sts.last     = last;
	assign sts.out_free = out_free;
	assign sts.div_done = div_done;

endmodule

`default_nettype wire

/* sv/block_power_squelch_top.sv */
// Block power squelch: a beat that does not end a block passes through ST_IDLE and ST_FWD, and
// its forwarded sample enters the output register at the ST_FWD commit. A beat that ends a block
// goes on through ST_START, ST_DIV (serial divider, one quotient bit per cycle over the 43-bit
// sum) and ST_RPT, where its power report enters the output register. Output stalls add cycles.
// Reset clears all control state asynchronously; the sample store has no clearing pass.
// Top level: joins controller and datapath; depends on bps_pkg, bps_ctrl, bps_dp and the defines header.
`default_nettype none
`include "block_power_squelch_top_defines.svh"

module block_power_squelch_top
	import bps_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [CFG_ADDR_BITS-1:0] cfg_addr,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	input  wire logic [STORE_BITS-1:0]    s_tdata,   // sample_i, sample_q
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	output logic [STORE_BITS+POWER_BITS-1:0] m_tdata, // out_i, out_q, power
	output logic                          m_tuser,   // kind
	output logic                          m_tlast    // block_last
);

	cmd_t cmd;
	sts_t sts;

	// Sequencing of each accepted beat.
	bps_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	// Store, power measurement and output beat.
	bps_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data),
		.s_tdata (s_tdata),
		.m_tready(m_tready),
		.m_tvalid(m_tvalid),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast),
		.cmd     (cmd),
		.sts     (sts)
	);

	// Checks on the controller and datapath handoff.
	`BPS_ASSERT_NXT(a_one_beat_at_a_time, clk, arst_n, s_tvalid && s_tready, !s_tready)
	`BPS_ASSERT_IMP(a_commit_has_slot, clk, arst_n, cmd.commit, sts.out_free)
	`BPS_ASSERT_IMP(a_report_after_div, clk, arst_n, cmd.report, sts.out_free && sts.div_done)
	`BPS_ASSERT_NXT(a_div_engages, clk, arst_n, cmd.div_start, !sts.div_done)

endmodule

`default_nettype wire

/* tb/tb_block_power_squelch_top.sv */
// Self-checking testbench for block_power_squelch_top: a directed opening, one full-size block,
// then randomized config phases checked against an in-bench squelch predictor.
// Depends on bps_pkg and the block_power_squelch_top RTL only.
module tb_block_power_squelch_top;
	import bps_pkg::*;

	localparam int QUIET_LIMIT = 5000;
	localparam int REST_CYCLES = 60;
	localparam int LONG_HOLD = 400;
	localparam int TOTAL_ITEMS = 1450;

	// One result beat as the block presents it.
	typedef struct packed {
		logic        kind;
		logic [15:0] out_i;
		logic [15:0] out_q;
		logic [31:0] power;
		logic        block_last;
	} squelch_result_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [CFG_ADDR_BITS-1:0]       cfg_addr = '0;
	logic [CFG_DATA_BITS-1:0]       cfg_data = '0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [STORE_BITS-1:0]          s_tdata = '0;    // sample_i, sample_q
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [STORE_BITS+POWER_BITS-1:0] m_tdata;       // out_i, out_q, power
	logic                           m_tuser;         // kind
	logic                           m_tlast;         // block_last

	block_power_squelch_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Stimulus and expectation stores.
	logic [STORE_BITS-1:0] pending_samples[$];
	squelch_result_t       expected_results[$];
	int unsigned           queued_cnt = 0;
	int unsigned           accepted_cnt = 0;
	int unsigned           error_cnt = 0;
	int unsigned           quiet_cycles = 0;
	bit                    in_taken = 1'b0;
	bit                    in_idle_on = 1'b1;
	bit                    out_idle_on = 1'b1;
	bit                    hold_request = 1'b0;
	int unsigned           send_gap = 0;
	int unsigned           ready_gap = 0;

	// Mirror of the configuration registers, at reset values.
	logic [10:0] len_reg = 11'd1024;
	logic [10:0] dec_reg = 11'd1;
	logic [31:0] level_reg = 32'd0;
	logic        cplx_reg = 1'b1;

	// Mirror of the block state.
	logic [31:0] block_copy [MAX_BLOCK];
	int unsigned wr_pos = 0;
	int unsigned stride_pos = 0;
	logic [41:0] energy_sum = '0;
	int unsigned taken = 0;
	mode_t       prior_mode = MODE_NONE;
	int unsigned flush_run = 0;

	// Most gaps are short, a few are long.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Zero acts as one, anything beyond the store saturates.
	function automatic int unsigned span_of(logic [10:0] v);
		if (v == 11'd0) return 1;
		if (v > 11'(MAX_BLOCK)) return MAX_BLOCK;
		return v;
	endfunction

	function automatic logic [15:0] noise_sample(int unsigned shift);
		logic signed [15:0] raw;
		int unsigned        r;
		raw = 16'($urandom);
		r = $urandom_range(0, 19);
		if (r == 0) return 16'h8000;
		if (r == 1) return 16'h7FFF;
		if (r == 2) return 16'h0000;
		return raw >>> shift;
	endfunction

	// Works out the results that one accepted sample causes.
	task automatic predict_squelch_step(input logic [STORE_BITS-1:0] beat);
		int unsigned     span;
		int unsigned     stride;
		int unsigned     pos;
		logic            ends;
		logic [15:0]     in_i;
		logic [15:0]     in_q;
		longint          vi;
		longint          vq;
		logic [41:0]     mean;
		squelch_result_t res;
		span = span_of(len_reg);
		stride = span_of(dec_reg);
		pos = wr_pos % MAX_BLOCK;
		ends = (pos + 1 >= span);
		in_i = beat[15:0];
		in_q = cplx_reg ? beat[31:16] : 16'd0;

		// The prior block comes out at the same position, as data or as zeros.
		if (prior_mode == MODE_PASS || prior_mode == MODE_FLUSH) begin
			res.kind = KIND_SAMPLE;
			res.out_i = (prior_mode == MODE_PASS) ? block_copy[pos][15:0] : 16'd0;
			res.out_q = (prior_mode == MODE_PASS) ? block_copy[pos][31:16] : 16'd0;
			res.power = '0;
			res.block_last = ends;
			expected_results.push_back(res);
		end
		block_copy[pos] = {in_q, in_i};

		// Every stride-th sample adds its energy.
		if (stride_pos == 0) begin
			vi = longint'($signed(in_i));
			vq = longint'($signed(in_q));
			energy_sum = energy_sum + 42'(vi * vi + vq * vq);
			taken++;
		end
		stride_pos++;
		if (stride_pos >= stride) stride_pos = 0;

		if (ends) begin
			mean = energy_sum / 42'(taken);
			if (mean > 42'hFFFF_FFFF) mean = 42'hFFFF_FFFF;
			res.kind = KIND_REPORT;
			res.out_i = '0;
			res.out_q = '0;
			res.power = mean[31:0];
			res.block_last = 1'b0;
			expected_results.push_back(res);
			if (level_reg == 32'd0 || mean >= 42'(level_reg)) begin
				prior_mode = MODE_PASS;
				flush_run = 0;
			end else if (flush_run < FLUSH_BLOCKS) begin
				prior_mode = MODE_FLUSH;
				flush_run++;
			end else begin
				prior_mode = MODE_DROP;
			end
			energy_sum = '0;
			taken = 0;
			stride_pos = 0;
			wr_pos = 0;
		end else begin
			wr_pos = pos + 1;
		end
	endtask

	// Input beats and result beats are both sampled at the rising edge.
	always @(posedge clk) begin
		squelch_result_t got;
		squelch_result_t want;
		if (m_tvalid && m_tready) begin
			got.kind = m_tuser;
			got.out_i = m_tdata[15:0];
			got.out_q = m_tdata[31:16];
			got.power = m_tdata[63:32];
			got.block_last = m_tlast;
			if (expected_results.size() == 0) begin
				$display("%0t: result with nothing expected: kind=%0d i=%h q=%h power=%h last=%0d",
					$time, got.kind, got.out_i, got.out_q, got.power, got.block_last);
				error_cnt++;
			end else begin
				want = expected_results.pop_front();
				if (got.kind !== want.kind || got.out_i !== want.out_i ||
				    got.out_q !== want.out_q || got.power !== want.power ||
				    got.block_last !== want.block_last) begin
					$display("%0t: mismatch expected kind=%0d i=%h q=%h power=%h last=%0d",
						$time, want.kind, want.out_i, want.out_q, want.power,
						want.block_last);
					$display("%0t:          actual   kind=%0d i=%h q=%h power=%h last=%0d",
						$time, got.kind, got.out_i, got.out_q, got.power, got.block_last);
					error_cnt++;
				end
			end
		end
		in_taken = s_tvalid && s_tready;
		if (in_taken) begin
			predict_squelch_step(s_tdata);
			accepted_cnt++;
		end
	end

	// Watchdog: too long without any beat or register write ends the run.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !arst_n) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Sample driver: offers the next pending sample after a random gap.
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || in_taken)) begin
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (pending_samples.size() > 0) begin
				s_tdata <= pending_samples.pop_front();
				s_tvalid <= 1'b1;
				if (in_idle_on) send_gap = pick_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result sink: random stalls, plus one long hold-off on request.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_request) begin
				hold_request = 1'b0;
				ready_gap = LONG_HOLD;
				m_tready <= 1'b0;
			end else if (ready_gap > 0) begin
				ready_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (out_idle_on) ready_gap = pick_gap();
			end
		end
	end

	task automatic send(input logic [15:0] si, input logic [15:0] sq);
		pending_samples.push_back({sq, si});
		queued_cnt++;
	endtask

	// Register writes happen only while the block is idle.
	task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx, input logic [31:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= value;
		case (idx)
			REG_BLOCK_LENGTH: len_reg = value[10:0];
			REG_DECIMATION: dec_reg = value[10:0];
			REG_SQUELCH_LEVEL: level_reg = value;
			REG_COMPLEX_MODE: cplx_reg = value[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Waits for every sample to be taken and every result to arrive, then
	// lets a division that produces nothing yet run out.
	task automatic wait_idle();
		while (accepted_cnt != queued_cnt || expected_results.size() != 0) @(posedge clk);
		repeat (REST_CYCLES) @(posedge clk);
	endtask

	initial begin
		int unsigned r;
		int unsigned n;
		int unsigned shift;
		int unsigned phase_no;
		logic [31:0] value;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Field extremes with the reset length: no block ends, nothing comes out.
		send(16'h7FFF, 16'h7FFF);
		send(16'h8000, 16'h8000);
		send(16'h0000, 16'h0000);
		send(16'hFFFF, 16'hFFFF);
		send(16'h0001, 16'h8000);
		send(16'h8000, 16'h7FFF);
		wait_idle();

		// Length shrunk below the write position: the next sample ends the block.
		write_reg(REG_BLOCK_LENGTH, 32'd3);
		send(16'h8000, 16'h8000);
		wait_idle();

		// Real mode with a stride of two; the prior block is forwarded.
		write_reg(REG_DECIMATION, 32'd2);
		write_reg(REG_COMPLEX_MODE, 32'd0);
		send(16'h7FFF, 16'h1234);
		send(16'hFFFF, 16'hFFFF);
		send(16'h5555, 16'hAAAA);
		wait_idle();

		// One-sample blocks against the highest level: three flushed blocks below it, a pass at full
		// scale, then five flushed blocks and drops after them.
		write_reg(REG_SQUELCH_LEVEL, 32'h8000_0000);
		write_reg(REG_BLOCK_LENGTH, 32'd1);
		write_reg(REG_COMPLEX_MODE, 32'd1);
		send(16'h0100, 16'hFF00);
		send(16'h7FFF, 16'h0000);
		send(16'h0000, 16'h8001);
		send(16'h8000, 16'h8000);
		for (int k = 0; k < 6; k++) send(noise_sample(2), noise_sample(2));
		wait_idle();

		// A full-size block with the widest stride while blocks are dropped,
		// so the whole store is written before any longer block reads it.
		write_reg(REG_BLOCK_LENGTH, 32'd2047);
		write_reg(REG_DECIMATION, 32'd1024);
		for (int k = 0; k < MAX_BLOCK; k++) send(noise_sample(0), noise_sample(0));
		wait_idle();

		// Random phases, each under a new mix of settings.
		phase_no = 0;
		while (queued_cnt < TOTAL_ITEMS) begin
			// The hold-off phase always gets a short length so that blocks end in it.
			if (phase_no == 1 || $urandom_range(0, 9) < 7) begin
				r = $urandom_range(0, 99);
				if (r < 8) value = 32'd0;
				else if (r < 16) value = 32'd1;
				else if (r < 26) value = $urandom_range(17, 64);
				else value = $urandom_range(2, 16);
				write_reg(REG_BLOCK_LENGTH, value);
			end
			if ($urandom_range(0, 1) == 1) begin
				r = $urandom_range(0, 9);
				if (r == 0) value = 32'd0;
				else if (r == 1) value = 32'd2047;
				else if (r == 2) value = 32'd1024;
				else value = $urandom_range(1, 6);
				write_reg(REG_DECIMATION, value);
			end
			if ($urandom_range(0, 1) == 1) begin
				r = $urandom_range(0, 9);
				if (r < 4) value = 32'd0;
				else if (r < 8) value = 32'd1 << $urandom_range(0, 31);
				else value = $urandom_range(0, 32'h8000_0000);
				write_reg(REG_SQUELCH_LEVEL, value);
			end
			if ($urandom_range(0, 3) == 0) write_reg(REG_COMPLEX_MODE, $urandom_range(0, 1));

			in_idle_on = ($urandom_range(0, 3) != 0);
			out_idle_on = ($urandom_range(0, 3) != 0);
			shift = $urandom_range(0, 15);
			n = $urandom_range(5, 40);

			// Early on, hold the sink off while samples keep coming.
			if (phase_no == 1) begin
				@(posedge clk);
				hold_request = 1'b1;
				in_idle_on = 1'b0;
				n = 80;
			end
			for (int k = 0; k < n; k++) begin
				if ($urandom_range(0, 4) == 0) shift = $urandom_range(0, 15);
				send(noise_sample(shift), noise_sample(shift));
			end
			wait_idle();
			phase_no++;
		end

		if (error_cnt == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+sv
sv/bps_pkg.sv
sv/bps_ram.sv
sv/bps_div.sv
sv/bps_ctrl.sv
sv/bps_dp.sv
sv/block_power_squelch_top.sv
tb/tb_block_power_squelch_top.sv
